/* rtl/core/gfo_pkg.sv */
// Shared types and constants for the gray frame orient and point filter.
// Used by the filter datapath, the top level, the checker and the bench.
`timescale 1ns / 1ps

package gfo_pkg;

	localparam int PIX_W  = 8;
	localparam int SUM_W  = 24;
	localparam int MODE_W = 4;

	localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

	// filter_mode codes
	localparam logic [MODE_W-1:0] MODE_BW      = 4'd0;
	localparam logic [MODE_W-1:0] MODE_INVERT  = 4'd1;
	localparam logic [MODE_W-1:0] MODE_MERGE   = 4'd2;
	localparam logic [MODE_W-1:0] MODE_FLIPH   = 4'd3;
	localparam logic [MODE_W-1:0] MODE_FLIPV   = 4'd4;
	localparam logic [MODE_W-1:0] MODE_FLIPHV  = 4'd5;
	localparam logic [MODE_W-1:0] MODE_ROT90   = 4'd6;
	localparam logic [MODE_W-1:0] MODE_ROT180  = 4'd7;
	localparam logic [MODE_W-1:0] MODE_ROT270  = 4'd8;
	localparam logic [MODE_W-1:0] MODE_LIGHTEN = 4'd9;
	localparam logic [MODE_W-1:0] MODE_DARKEN  = 4'd10;

	// request kinds carried on tuser
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_READ  = 1'b1;

	typedef struct packed {
		logic [PIX_W-1:0] second;
		logic [PIX_W-1:0] first;
	} pix_pair_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK
	} state_t;

endpackage

/* rtl/core/gray_frame_orient_and_point_filter.sv */
// Channel   | Handshake                      | Payload
// s_axis    | s_axis_tvalid / s_axis_tready  | tdata: row, col, pixel_value, second_value
//           |                                | tuser: func (0 write, 1 read)
// m_axis    | m_axis_tvalid / m_axis_tready  | tdata: out_pixel
// cfg       | cfg_valid / cfg_ready          | cfg_data: filter_mode
//
// A request first reads the pixel pair from the single-port frame store in ST_IDLE, then in
// ST_LOOK writes it back (write) or filters it into the output register (read).
// After reset a clearing pass zeroes the store, one entry a cycle, over all 2^(2*CW)
// addresses (65536 at SIDE = 256); s_axis_tready stays low until it ends.
// A read result waits in the output register; a stalled m_axis holds the next read
// in ST_LOOK. Writes produce no result.
// Depends on gfo_pkg, gfo_mem and gfo_filter.
`timescale 1ns / 1ps

module gray_frame_orient_and_point_filter
	import gfo_pkg::*;
#(
	parameter int SIDE = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // row[7:0], col[15:8], pixel_value[23:16], second_value[31:24]
	input  logic [0:0]  s_axis_tuser,  // func[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // out_pixel[7:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data       // filter_mode[3:0]
);

	localparam int LW   = $clog2(SIDE);
	localparam int CW   = $clog2((SIDE < 256) ? SIDE : 256);
	localparam int AW   = 2 * CW;
	localparam int XW   = ((LW > 8) ? LW : 8) + 1;
	localparam int NPIX = SIDE * SIDE;
	localparam int DW   = $bits(pix_pair_t);

	state_t state_q, state_d;

	logic [MODE_W-1:0] mode_q;
	logic [SUM_W-1:0]  sum_q;
	logic [AW-1:0]     clr_q;

	logic [XW-1:0] rx, cx, lastx, sr, sc;
	logic          in_frame, src_hi, is_rd, acc;
	logic [AW-1:0] rd_addr;

	logic             rd_s1, inside_s1, zero_s1;
	logic [AW-1:0]    addr_s1;
	logic [PIX_W-1:0] pix_s1, sec_s1;

	logic          mem_en, mem_we;
	logic [AW-1:0] mem_addr;
	pix_pair_t     mem_wdata, mem_rdata;

	logic [PIX_W-1:0] filt;
	logic             m_valid_q, out_ld;
	logic [PIX_W-1:0] m_data_q;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign is_rd         = (s_axis_tuser[0] == FUNC_READ);

	assign rx       = XW'(s_axis_tdata[7:0]);
	assign cx       = XW'(s_axis_tdata[15:8]);
	assign lastx    = XW'(SIDE - 1);
	assign in_frame = (rx < XW'(SIDE)) && (cx < XW'(SIDE));

	// source coordinate of the output pixel under the current orientation
	always_comb begin
		sr = rx;
		sc = cx;
		if (is_rd) begin
			case (mode_q) inside
				MODE_FLIPH: sc = lastx - cx;
				MODE_FLIPV: sr = lastx - rx;
				MODE_FLIPHV, MODE_ROT180: begin
					sr = lastx - rx;
					sc = lastx - cx;
				end
				MODE_ROT90: begin
					sr = lastx - cx;
					sc = rx;
				end
				MODE_ROT270: begin
					sr = cx;
					sc = lastx - rx;
				end
				default: ;
			endcase
		end
	end

	// a source beyond the addressable coordinates was never written and reads as zero
	assign src_hi  = (sr > XW'(PIX_MAX)) || (sc > XW'(PIX_MAX));
	assign rd_addr = {sr[CW-1:0], sc[CW-1:0]};

	always_comb begin
		mem_en    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = rd_addr;
		mem_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_en   = 1'b1;
				mem_we   = 1'b1;
				mem_addr = clr_q;
			end
			ST_IDLE: begin
				mem_en = acc && in_frame && !src_hi;
			end
			ST_LOOK: begin
				mem_en           = !rd_s1 && inside_s1;
				mem_we           = 1'b1;
				mem_addr         = addr_s1;
				mem_wdata.first  = pix_s1;
				mem_wdata.second = sec_s1;
			end
			default: ;
		endcase
	end

	gfo_mem #(
		.AW(AW),
		.DW(DW)
	) u_mem (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	gfo_filter #(
		.NPIX(NPIX)
	) u_filter (
		.mode   (mode_q),
		.pair   (mem_rdata),
		.sum    (sum_q),
		.result (filt)
	);

	assign out_ld = (state_q == ST_LOOK) && rd_s1 && (!m_valid_q || m_axis_tready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == '1) state_d = ST_IDLE;
			ST_IDLE:  if (acc) state_d = ST_LOOK;
			ST_LOOK:  if (!rd_s1 || out_ld) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == ST_CLEAR) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_BW;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rd_s1     <= is_rd;
			inside_s1 <= in_frame;
			zero_s1   <= !in_frame || src_hi;
			addr_s1   <= rd_addr;
			pix_s1    <= s_axis_tdata[23:16];
			sec_s1    <= s_axis_tdata[31:24];
		end
	end

	// replace the old first-frame pixel in the running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (state_q == ST_LOOK && !rd_s1 && inside_s1) begin
			sum_q <= sum_q - SUM_W'(mem_rdata.first) + SUM_W'(pix_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_ld) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			m_data_q <= zero_s1 ? '0 : filt;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

/* rtl/core/gfo_mem.sv */
// Single-port synchronous frame store with registered read data.
// Holds the first and second frame pixel pairs; no dependencies.
`timescale 1ns / 1ps

module gfo_mem #(
	parameter int AW = 16,
	parameter int DW = 16
) (
	input  logic          clk,
	input  logic          en,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [DW-1:0] wdata,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [2**AW];

	always_ff @(posedge clk) begin
		if (en && we) begin
			mem_q[addr] <= wdata;
		end
	end

	// hold read data between reads
	always_ff @(posedge clk) begin
		if (en && !we) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

/* rtl/core/gfo_filter.sv */
// Point filter datapath: maps one stored pixel pair to an output gray level.
// Depends on gfo_pkg for mode codes and the pixel pair type.
`timescale 1ns / 1ps

module gfo_filter
	import gfo_pkg::*;
#(
	parameter int NPIX = 65536
) (
	input  logic [MODE_W-1:0] mode,
	input  pix_pair_t         pair,
	input  logic [SUM_W-1:0]  sum,
	output logic [PIX_W-1:0]  result
);

	localparam int NB = $clog2(NPIX + 1);
	localparam int PW = (PIX_W + NB > SUM_W) ? PIX_W + NB : SUM_W + 1;

	logic [PW-1:0]    prod;
	logic             above_mean;
	logic [PIX_W:0]   merge_sum;
	logic [PIX_W-1:0] p;

	assign p = pair.first;

	// p > floor(sum / NPIX) exactly when sum < p * NPIX
	assign prod       = PW'(p) * PW'(NPIX);
	assign above_mean = PW'(sum) < prod;
	assign merge_sum  = {1'b0, p} + {1'b0, pair.second};

	always_comb begin
		case (mode)
			MODE_BW:      result = above_mean ? PIX_MAX : '0;
			MODE_INVERT:  result = PIX_MAX - p;
			MODE_MERGE:   result = merge_sum[PIX_W:1];
			MODE_LIGHTEN: result = p + ((PIX_MAX - p) >> 1);
			MODE_DARKEN:  result = p >> 1;
			// orientation modes and unused codes pass the fetched pixel
			default:      result = p;
		endcase
	end

endmodule

/* rtl/core/gfo_chk.sv */
// Port-level checker for gray_frame_orient_and_point_filter, bound to the top level.
// Depends only on the top level's ports and gfo_pkg request kinds.
`timescale 1ns / 1ps

module gfo_chk
	import gfo_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [0:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	logic acc;
	assign acc = s_axis_tvalid && s_axis_tready;

	// a stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// one request at a time: busy in the cycle after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> !s_axis_tready)
		else $error("request accepted while previous one in flight");

	// a read request leads to a result offered on m_axis
	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		acc && s_axis_tuser[0] == FUNC_READ |=> ##1 m_axis_tvalid)
		else $error("read request produced no result");

	// a write request never raises a result
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		acc && s_axis_tuser[0] == FUNC_WRITE |=> ##1 !$rose(m_axis_tvalid))
		else $error("write request produced a result");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write not taken");

endmodule

bind gray_frame_orient_and_point_filter gfo_chk u_gfo_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.cfg_valid     (cfg_valid),
	.cfg_ready     (cfg_ready)
);

/* bench/testbench.sv */
// Self-checking bench for gray_frame_orient_and_point_filter: writes and reads pixel
// requests under random stalls and compares each read result with an in-bench frame predictor.
// Depends on gfo_pkg and the block's top level only.
`timescale 1ns / 1ps

module testbench;
	import gfo_pkg::*;

	localparam int SIDE        = 256;
	localparam int DRAIN_WAIT  = 8;
	localparam int FINAL_LIMIT = 5000;
	localparam logic [MODE_W-1:0] MODE_TOP = 4'hF;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [31:0]       s_axis_tdata;
	logic [0:0]        s_axis_tuser;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [7:0]        m_axis_tdata;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [3:0]        cfg_data;

	// predictor state
	logic [PIX_W-1:0]  first_store [SIDE*SIDE];
	logic [PIX_W-1:0]  second_store [SIDE*SIDE];
	logic [SUM_W-1:0]  frame_sum;
	logic [MODE_W-1:0] filter_mode;
	logic [PIX_W-1:0]  pending_pixels [$];

	int mismatches;
	bit src_idle_en;
	bit sink_idle_en;

	gray_frame_orient_and_point_filter #(
		.SIDE(SIDE)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#4_800_000;
		$display("testbench: done, errors");
		$finish;
	end

	function automatic logic [PIX_W-1:0] filtered_pixel(int r, int c);
		int last;
		int p;
		int mean;
		last = SIDE - 1;
		if (r >= SIDE || c >= SIDE)
			return '0;
		p = first_store[r*SIDE + c];
		mean = frame_sum / (SIDE*SIDE);
		case (filter_mode)
			MODE_BW:      return (p > mean) ? PIX_MAX : '0;
			MODE_INVERT:  return PIX_W'(255 - p);
			MODE_MERGE:   return PIX_W'((p + second_store[r*SIDE + c]) >> 1);
			MODE_FLIPH:   return first_store[r*SIDE + (last - c)];
			MODE_FLIPV:   return first_store[(last - r)*SIDE + c];
			MODE_FLIPHV,
			MODE_ROT180:  return first_store[(last - r)*SIDE + (last - c)];
			MODE_ROT90:   return first_store[(last - c)*SIDE + r];
			MODE_ROT270:  return first_store[c*SIDE + (last - r)];
			MODE_LIGHTEN: return PIX_W'(p + ((255 - p) >> 1));
			MODE_DARKEN:  return PIX_W'(p >> 1);
			default:      return PIX_W'(p);
		endcase
	endfunction

	task automatic record_write(int r, int c, logic [PIX_W-1:0] pv, logic [PIX_W-1:0] sv);
		int k;
		if (r < SIDE && c < SIDE) begin
			k = r*SIDE + c;
			frame_sum = frame_sum - SUM_W'(first_store[k]) + SUM_W'(pv);
			first_store[k] = pv;
			second_store[k] = sv;
		end
	endtask

	// Drive one request and hold it until the block takes it.
	task automatic send_request(logic func, logic [7:0] r, logic [7:0] c,
			logic [PIX_W-1:0] pv, logic [PIX_W-1:0] sv);
		int gap;
		@(negedge clk);
		if (src_idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {sv, pv, c, r};
		s_axis_tuser  <= func;
		do @(posedge clk); while (!s_axis_tready);
		if (func == FUNC_WRITE)
			record_write(r, c, pv, sv);
		else
			pending_pixels.push_back(filtered_pixel(r, c));
	endtask

	task automatic stop_requests();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_pixels.size() != 0) @(posedge clk);
		// writes leave no result behind, so give the pipeline time to empty
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic set_mode(logic [MODE_W-1:0] m);
		stop_requests();
		wait_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		do @(posedge clk); while (!cfg_ready);
		filter_mode = m;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Favor the corner rows and columns so flips and rotations land on written pixels.
	function automatic logic [7:0] pick_coord();
		int k;
		if ($urandom_range(0, 6) == 0)
			return 8'($urandom);
		k = $urandom_range(0, 7);
		return (k < 4) ? 8'(k) : 8'(248 + k);
	endfunction

	// Small values sit near the frame mean, which keeps black and white interesting.
	function automatic logic [PIX_W-1:0] pick_pixel();
		int k;
		k = $urandom_range(0, 9);
		if (k < 3)
			return PIX_W'($urandom_range(0, 4));
		if (k == 3)
			return PIX_MAX;
		return PIX_W'($urandom);
	endfunction

	task automatic send_random_request();
		logic func;
		func = ($urandom_range(0, 1) == 0) ? FUNC_WRITE : FUNC_READ;
		send_request(func, pick_coord(), pick_coord(), pick_pixel(), pick_pixel());
	endtask

	task automatic test_directed_modes();
		send_request(FUNC_WRITE, 8'd0,   8'd0,   8'd200, 8'd55);
		send_request(FUNC_WRITE, 8'd0,   8'd255, 8'd17,  8'd3);
		send_request(FUNC_WRITE, 8'd255, 8'd0,   8'd255, 8'd255);
		send_request(FUNC_WRITE, 8'd255, 8'd255, 8'd1,   8'd0);
		send_request(FUNC_WRITE, 8'd0,   8'd1,   8'd90,  8'd91);
		// overwrite a pixel so the sum drops the old value
		send_request(FUNC_WRITE, 8'd0,   8'd0,   8'd60,  8'd201);
		for (int m = 0; m <= MODE_TOP; m++) begin
			set_mode(MODE_W'(m));
			send_request(FUNC_READ, 8'd0, 8'd0, 8'd0, 8'd0);
		end
		send_request(FUNC_READ, 8'd255, 8'd255, PIX_MAX, PIX_MAX);
	endtask

	task automatic test_random_traffic();
		logic [MODE_W-1:0] m;
		for (int phase = 0; phase < 10; phase++) begin
			case (phase)
				0:       m = MODE_BW;
				1:       m = MODE_DARKEN;
				2:       m = MODE_TOP;
				default: m = MODE_W'($urandom_range(0, MODE_TOP));
			endcase
			set_mode(m);
			for (int n = 0; n < 130; n++) begin
				// hold off once mid-phase until every read result is back
				if (phase == 5 && n == 65) begin
					stop_requests();
					wait_drained();
				end
				send_random_request();
			end
		end
	endtask

	task automatic test_no_idle_tail();
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		set_mode(MODE_W'($urandom_range(0, MODE_TOP)));
		repeat (200) send_random_request();
	endtask

	// result sink with random stall bursts
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_idle_en && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0d", $time, m_axis_tdata);
				mismatches++;
			end else begin
				if (m_axis_tdata !== pending_pixels[0]) begin
					$display("%0t: out_pixel mismatch, expected %0d, actual %0d",
						$time, pending_pixels[0], m_axis_tdata);
					mismatches++;
				end
				void'(pending_pixels.pop_front());
			end
		end
	end

	initial begin
		int waited;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = FUNC_WRITE;
		cfg_valid     = 1'b0;
		cfg_data      = MODE_BW;
		arst_n        = 1'b0;
		frame_sum     = '0;
		filter_mode   = MODE_BW;
		mismatches    = 0;
		src_idle_en   = 1'b1;
		sink_idle_en  = 1'b1;
		for (int k = 0; k < SIDE*SIDE; k++) begin
			first_store[k]  = '0;
			second_store[k] = '0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_modes();
		test_random_traffic();
		test_no_idle_tail();

		stop_requests();
		waited = 0;
		while (pending_pixels.size() != 0 && waited < FINAL_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_WAIT) @(posedge clk);
		if (pending_pixels.size() != 0) begin
			$display("%0t: missing results, expected %0d more, actual 0",
				$time, pending_pixels.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
